// File: src/assert_macros.svh
// Assertion macros shared by the scalar register move unit.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define SMRU_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted
`define SMRU_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// File: src/smru_pkg.sv
// Package for the scalar register move unit: field widths, codes,
// controller/datapath command and status structs. No dependencies.
`default_nettype none

package smru_pkg;

    // Default register file size
    localparam int unsigned SMRU_REG_COUNT = 128;

    // Field widths
    localparam int unsigned CMD_W   = 2;
    localparam int unsigned IDX_W   = 8;
    localparam int unsigned KIND_W  = 3;
    localparam int unsigned WORD_W  = 32;
    localparam int unsigned CODE_W  = 2;
    localparam int unsigned ROLE_W  = 2;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 64;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_MOV32 = 2'd0;
    localparam logic [CMD_W-1:0] CMD_MOV64 = 2'd1;

    // Source kinds
    localparam logic [KIND_W-1:0] KIND_REG     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_VCC_LO  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_VCC_HI  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_M0      = 3'd3;
    localparam logic [KIND_W-1:0] KIND_NULL    = 3'd4;
    localparam logic [KIND_W-1:0] KIND_EXEC_LO = 3'd5;
    localparam logic [KIND_W-1:0] KIND_EXEC_HI = 3'd6;
    localparam logic [KIND_W-1:0] KIND_IMM     = 3'd7;

    // Error codes
    localparam logic [CODE_W-1:0] ERR_OK          = 2'd0;
    localparam logic [CODE_W-1:0] ERR_INDEX       = 2'd1;
    localparam logic [CODE_W-1:0] ERR_PAIR        = 2'd2;
    localparam logic [CODE_W-1:0] ERR_UNSUPPORTED = 2'd3;

    // Operand roles
    localparam logic [ROLE_W-1:0] ROLE_NONE   = 2'd0;
    localparam logic [ROLE_W-1:0] ROLE_SOURCE = 2'd1;
    localparam logic [ROLE_W-1:0] ROLE_DEST   = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_VCC  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXEC = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_M0   = 2'd2;

    // Controller -> datapath commands
    typedef struct packed {
        logic load_item;
        logic rd_issue;
        logic rd_hi;
        logic cap_lo;
        logic cap_hi;
        logic wr_en;
        logic wr_hi;
        logic load_result;
    } t_dp_cmd;

    // Datapath -> controller status
    typedef struct packed {
        logic err;
        logic wide;
        logic use_ram;
        logic out_free;
    } t_dp_status;

endpackage

`default_nettype wire

// File: src/smru_in_if.sv
// Input channel of the scalar register move unit: valid/ready plus item.
// Depends on smru_pkg for field widths.
`default_nettype none

interface smru_in_if import smru_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [IDX_W-1:0]  dest_index;
    logic [KIND_W-1:0] source_kind;
    logic [IDX_W-1:0]  source_index;
    logic [WORD_W-1:0] immediate;

    modport source (output valid, cmd, dest_index, source_kind, source_index, immediate,
                    input ready);
    modport sink   (input valid, cmd, dest_index, source_kind, source_index, immediate,
                    output ready);
endinterface

`default_nettype wire

// File: src/smru_out_if.sv
// Result channel of the scalar register move unit: valid/ready plus item.
// Depends on smru_pkg for field widths.
`default_nettype none

interface smru_out_if import smru_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CODE_W-1:0] error_code;
    logic [ROLE_W-1:0] error_role;
    logic [IDX_W-1:0]  error_index;
    logic              wide_write;
    logic [IDX_W-1:0]  first_written;
    logic [WORD_W-1:0] value_low;
    logic [WORD_W-1:0] value_high;

    modport source (output valid, error_code, error_role, error_index, wide_write,
                    first_written, value_low, value_high, input ready);
    modport sink   (input valid, error_code, error_role, error_index, wide_write,
                    first_written, value_low, value_high, output ready);
endinterface

`default_nettype wire

// File: src/scalar_register_move_unit.sv
// Scalar register move unit, one item at a time through a registered-read RAM.
// A 32-bit move steps through check, low read, low write and done; a 64-bit move
// adds a high read and a high write; an error goes from check straight to done.
// The next item is taken the cycle after the result is registered, and done waits while the result is held.
// Reset (synchronous, active low) clears config registers, the written flags
// of the register file (all entries read as zero) and the sequencer.
`default_nettype none

`include "assert_macros.svh"

module scalar_register_move_unit import smru_pkg::*; #(
    parameter int unsigned REG_COUNT = SMRU_REG_COUNT
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    smru_in_if.sink                    i_in,
    smru_out_if.source                 o_out,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);
    t_dp_cmd    w_cmd;
    t_dp_status w_status;
    logic       w_in_ready;

    // Result properties used by the checks
    logic w_res_ok;
    logic w_res_err;
    logic w_res_narrow;
    logic w_ok_clean;
    logic w_err_clean;
    logic w_hi_zero;

    assign i_in.ready = w_in_ready;

    // Sequencer
    smru_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // Datapath
    smru_dpath #(
        .REG_COUNT (REG_COUNT)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_cmd_code      (i_in.cmd),
        .i_dest_index    (i_in.dest_index),
        .i_source_kind   (i_in.source_kind),
        .i_source_index  (i_in.source_index),
        .i_immediate     (i_in.immediate),
        .i_out_ready     (o_out.ready),
        .o_out_valid     (o_out.valid),
        .o_error_code    (o_out.error_code),
        .o_error_role    (o_out.error_role),
        .o_error_index   (o_out.error_index),
        .o_wide_write    (o_out.wide_write),
        .o_first_written (o_out.first_written),
        .o_value_low     (o_out.value_low),
        .o_value_high    (o_out.value_high)
    );

    // Result field relations
    assign w_res_ok     = o_out.valid && (o_out.error_code == ERR_OK);
    assign w_res_err    = o_out.valid && (o_out.error_code != ERR_OK);
    assign w_res_narrow = o_out.valid && !o_out.wide_write;
    assign w_ok_clean   = (o_out.error_role == ROLE_NONE) && (o_out.error_index == '0);
    assign w_err_clean  = !o_out.wide_write && (o_out.first_written == '0)
                          && (o_out.value_low == '0) && (o_out.value_high == '0);
    assign w_hi_zero    = (o_out.value_high == '0);

    // Checks
    `SMRU_ASSERT_NXT(a_one_item, i_clk, i_rst_n, i_in.valid && w_in_ready, !w_in_ready)
    `SMRU_ASSERT_IMP(a_ok_clean, i_clk, i_rst_n, w_res_ok, w_ok_clean)
    `SMRU_ASSERT_IMP(a_err_clean, i_clk, i_rst_n, w_res_err, w_err_clean)
    `SMRU_ASSERT_IMP(a_narrow_hi, i_clk, i_rst_n, w_res_narrow, w_hi_zero)
endmodule

`default_nettype wire

// File: src/smru_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module smru_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 128,
    localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AddrW-1:0] i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AddrW-1:0] i_raddr,
    output      logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule

`default_nettype wire

// File: src/smru_ctrl.sv
// Sequencer of the scalar register move unit: check, read, write, report.
// Depends on smru_pkg for the command and status structs.
`default_nettype none

module smru_ctrl import smru_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output      logic       o_in_ready,
    input  wire t_dp_status i_status,
    output      t_dp_cmd    o_cmd
);
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_RD_LO,
        ST_RD_HI,
        ST_WR_LO,
        ST_WR_HI,
        ST_DONE
    } t_state;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and datapath commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready      = 1'b1;
                o_cmd.load_item = i_in_valid;
                if (i_in_valid) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                // first source word read (only for register sources)
                o_cmd.rd_issue = i_status.use_ram && !i_status.err;
                n_state = i_status.err ? ST_DONE : ST_RD_LO;
            end
            ST_RD_LO: begin
                o_cmd.cap_lo = 1'b1;
                if (i_status.wide) begin
                    o_cmd.rd_issue = 1'b1;
                    o_cmd.rd_hi    = 1'b1;
                    n_state        = ST_RD_HI;
                end else begin
                    n_state = ST_WR_LO;
                end
            end
            ST_RD_HI: begin
                o_cmd.cap_hi = 1'b1;
                n_state      = ST_WR_LO;
            end
            ST_WR_LO: begin
                o_cmd.wr_en = 1'b1;
                n_state     = i_status.wide ? ST_WR_HI : ST_DONE;
            end
            ST_WR_HI: begin
                o_cmd.wr_en = 1'b1;
                o_cmd.wr_hi = 1'b1;
                n_state     = ST_DONE;
            end
            ST_DONE: begin
                // wait for the result register to free up
                if (i_status.out_free) begin
                    o_cmd.load_result = 1'b1;
                    n_state           = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end
endmodule

`default_nettype wire

// File: src/smru_dpath.sv
// Datapath of the scalar register move unit: item and config registers,
// operand checks, source select, register file with valid bits, result.
// Depends on smru_pkg and smru_ram.
`default_nettype none

module smru_dpath import smru_pkg::*; #(
    parameter int unsigned REG_COUNT = SMRU_REG_COUNT
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_dp_cmd               i_cmd,
    output      t_dp_status            o_status,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic [CMD_W-1:0]      i_cmd_code,
    input  wire logic [IDX_W-1:0]      i_dest_index,
    input  wire logic [KIND_W-1:0]     i_source_kind,
    input  wire logic [IDX_W-1:0]      i_source_index,
    input  wire logic [WORD_W-1:0]     i_immediate,
    input  wire logic                  i_out_ready,
    output      logic                  o_out_valid,
    output      logic [CODE_W-1:0]     o_error_code,
    output      logic [ROLE_W-1:0]     o_error_role,
    output      logic [IDX_W-1:0]      o_error_index,
    output      logic                  o_wide_write,
    output      logic [IDX_W-1:0]      o_first_written,
    output      logic [WORD_W-1:0]     o_value_low,
    output      logic [WORD_W-1:0]     o_value_high
);
    localparam int unsigned AddrW = $clog2(REG_COUNT);
    localparam logic [IDX_W:0] CountW = (IDX_W + 1)'(REG_COUNT);

    // Item registers
    logic [CMD_W-1:0]  r_cmd;
    logic [IDX_W-1:0]  r_dst;
    logic [KIND_W-1:0] r_kind;
    logic [IDX_W-1:0]  r_src;
    logic [WORD_W-1:0] r_imm;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_cmd  <= i_cmd_code;
            r_dst  <= i_dest_index;
            r_kind <= i_source_kind;
            r_src  <= i_source_index;
            r_imm  <= i_immediate;
        end
    end

    // Configuration registers
    logic [2*WORD_W-1:0] r_vcc;
    logic [2*WORD_W-1:0] r_exec;
    logic [WORD_W-1:0]   r_m0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcc  <= '0;
            r_exec <= '0;
            r_m0   <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_VCC) begin
                r_vcc <= i_cfg_data;
            end
            if (i_cfg_index == CFG_EXEC) begin
                r_exec <= i_cfg_data;
            end
            if (i_cfg_index == CFG_M0) begin
                r_m0 <= i_cfg_data[WORD_W-1:0];
            end
        end
    end

    // Operand checks
    logic is_mov32, is_mov64, dst_ok, src_ok, dst_pair_ok, src_pair_ok;
    assign is_mov32    = (r_cmd == CMD_MOV32);
    assign is_mov64    = (r_cmd == CMD_MOV64);
    assign dst_ok      = ({1'b0, r_dst} < CountW);
    assign src_ok      = ({1'b0, r_src} < CountW);
    assign dst_pair_ok = !r_dst[0] && (({1'b0, r_dst} + (IDX_W + 1)'(1)) < CountW);
    assign src_pair_ok = !r_src[0] && (({1'b0, r_src} + (IDX_W + 1)'(1)) < CountW);

    // Error classification, destination checked before source
    logic [CODE_W-1:0] err_code;
    logic [ROLE_W-1:0] err_role;
    logic [IDX_W-1:0]  err_index;

    always_comb begin
        err_code  = ERR_OK;
        err_role  = ROLE_NONE;
        err_index = '0;
        priority if (is_mov32) begin
            if (!dst_ok) begin
                err_code  = ERR_INDEX;
                err_role  = ROLE_DEST;
                err_index = r_dst;
            end else if (r_kind == KIND_REG && !src_ok) begin
                err_code  = ERR_INDEX;
                err_role  = ROLE_SOURCE;
                err_index = r_src;
            end
        end else if (is_mov64) begin
            if (!dst_pair_ok) begin
                err_code  = ERR_PAIR;
                err_role  = ROLE_DEST;
                err_index = r_dst;
            end else if (!src_pair_ok) begin
                err_code  = ERR_PAIR;
                err_role  = ROLE_SOURCE;
                err_index = r_src;
            end
        end else begin
            err_code = ERR_UNSUPPORTED;
        end
    end

    // Non-register source select
    logic [WORD_W-1:0] src_word;
    always_comb begin
        unique case (r_kind)
            KIND_VCC_LO:  src_word = r_vcc[WORD_W-1:0];
            KIND_VCC_HI:  src_word = r_vcc[2*WORD_W-1:WORD_W];
            KIND_M0:      src_word = r_m0;
            KIND_EXEC_LO: src_word = r_exec[WORD_W-1:0];
            KIND_EXEC_HI: src_word = r_exec[2*WORD_W-1:WORD_W];
            KIND_IMM:     src_word = r_imm;
            default:      src_word = '0;
        endcase
    end

    // Register file addressing; the odd word of a pair sets bit 0
    logic [AddrW-1:0]  src_addr, dst_addr, rd_addr, wr_addr;
    logic [WORD_W-1:0] wr_data, rd_data;
    logic [WORD_W-1:0] r_lo, r_hi;

    assign src_addr = r_src[AddrW-1:0];
    assign dst_addr = r_dst[AddrW-1:0];
    assign rd_addr  = i_cmd.rd_hi ? (src_addr | AddrW'(1)) : src_addr;
    assign wr_addr  = i_cmd.wr_hi ? (dst_addr | AddrW'(1)) : dst_addr;
    assign wr_data  = i_cmd.wr_hi ? r_hi : r_lo;

    smru_ram #(
        .WIDTH (WORD_W),
        .DEPTH (REG_COUNT)
    ) u_regs (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_re    (i_cmd.rd_issue),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    // Written flags: an entry never written reads as zero
    logic [REG_COUNT-1:0] r_written;
    logic                 r_rd_written;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written <= '0;
        end else if (i_cmd.wr_en) begin
            r_written[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_issue) begin
            r_rd_written <= r_written[rd_addr];
        end
    end

    // Operand capture
    logic [WORD_W-1:0] ram_word;
    assign ram_word = r_rd_written ? rd_data : '0;

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_lo) begin
            r_lo <= o_status.use_ram ? ram_word : src_word;
            r_hi <= '0;
        end else if (i_cmd.cap_hi) begin
            r_hi <= ram_word;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.load_result) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_result) begin
            o_error_code  <= err_code;
            o_error_role  <= err_role;
            o_error_index <= err_index;
            if (err_code == ERR_OK) begin
                o_wide_write    <= is_mov64;
                o_first_written <= r_dst;
                o_value_low     <= r_lo;
                o_value_high    <= r_hi;
            end else begin
                o_wide_write    <= 1'b0;
                o_first_written <= '0;
                o_value_low     <= '0;
                o_value_high    <= '0;
            end
        end
    end

    // Status to the sequencer
    assign o_status.err      = (err_code != ERR_OK);
    assign o_status.wide     = is_mov64;
    assign o_status.use_ram  = is_mov64 || (r_kind == KIND_REG);
    assign o_status.out_free = !o_out_valid || i_out_ready;
endmodule

`default_nettype wire

// File: tb/testbench.sv
// Self-checking testbench for the scalar register move unit: directed and random moves
// against a shadow register file, with random stalls on both channels.
// Depends on smru_pkg, smru_in_if, smru_out_if and the RTL top level.
`timescale 1ns / 100ps

module testbench;
    import smru_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT  = 2000;
    localparam int unsigned RANDOM_PHASES   = 6;
    localparam int unsigned ITEMS_PER_PHASE = 285;
    localparam int unsigned CALM_FROM       = 800;
    localparam int unsigned CALM_TO         = 1100;
    localparam int unsigned STALL_PERCENT   = 29;

    // Codes the package leaves unnamed: both fall through to unsupported
    localparam logic [CMD_W-1:0] CMD_OTHER     = 2'd2;
    localparam logic [CMD_W-1:0] CMD_UNDEFINED = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [IDX_W-1:0]  dest;
        logic [KIND_W-1:0] kind;
        logic [IDX_W-1:0]  src;
        logic [WORD_W-1:0] imm;
    } t_move_item;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [ROLE_W-1:0] role;
        logic [IDX_W-1:0]  bad_index;
        logic              wide;
        logic [IDX_W-1:0]  first_idx;
        logic [WORD_W-1:0] word_lo;
        logic [WORD_W-1:0] word_hi;
    } t_move_report;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    smru_in_if  io_in ();
    smru_out_if io_out ();

    scalar_register_move_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (io_in),
        .o_out       (io_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Shadow copy of the register file and of the config registers
    logic [WORD_W-1:0] sreg_shadow [SMRU_REG_COUNT];
    logic [63:0]       vcc_shadow;
    logic [63:0]       exec_shadow;
    logic [WORD_W-1:0] m0_shadow;

    t_move_item   move_queue [$];     // items waiting for the driver
    t_move_report report_queue [$];   // predicted reports, oldest first

    int unsigned issued_total;
    int unsigned accepted_total;
    int unsigned stuck_cycles;
    int unsigned mismatches;
    logic        in_taken;
    logic        calm;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic bit pair_fits(logic [IDX_W-1:0] idx);
        return idx[0] == 1'b0 && int'(idx) + 1 < SMRU_REG_COUNT;
    endfunction

    // Executes one move on the shadow file and returns the report it produces
    function automatic t_move_report predict_move(t_move_item it);
        t_move_report r;
        logic [WORD_W-1:0] lo;
        logic [WORD_W-1:0] hi;
        r = '0;
        lo = '0;
        hi = '0;
        if (it.cmd == CMD_MOV32) begin
            if (it.dest >= SMRU_REG_COUNT) begin
                r.code = ERR_INDEX;
                r.role = ROLE_DEST;
                r.bad_index = it.dest;
            end else if (it.kind == KIND_REG && it.src >= SMRU_REG_COUNT) begin
                r.code = ERR_INDEX;
                r.role = ROLE_SOURCE;
                r.bad_index = it.src;
            end else begin
                case (it.kind)
                    KIND_REG:     lo = sreg_shadow[it.src];
                    KIND_VCC_LO:  lo = vcc_shadow[31:0];
                    KIND_VCC_HI:  lo = vcc_shadow[63:32];
                    KIND_M0:      lo = m0_shadow;
                    KIND_NULL:    lo = '0;
                    KIND_EXEC_LO: lo = exec_shadow[31:0];
                    KIND_EXEC_HI: lo = exec_shadow[63:32];
                    default:      lo = it.imm;
                endcase
                sreg_shadow[it.dest] = lo;
                r.first_idx = it.dest;
                r.word_lo = lo;
            end
        end else if (it.cmd == CMD_MOV64) begin
            // kind and immediate play no part in a pair move
            if (!pair_fits(it.dest)) begin
                r.code = ERR_PAIR;
                r.role = ROLE_DEST;
                r.bad_index = it.dest;
            end else if (!pair_fits(it.src)) begin
                r.code = ERR_PAIR;
                r.role = ROLE_SOURCE;
                r.bad_index = it.src;
            end else begin
                // both source words are read before either write
                lo = sreg_shadow[it.src];
                hi = sreg_shadow[int'(it.src) + 1];
                sreg_shadow[it.dest] = lo;
                sreg_shadow[int'(it.dest) + 1] = hi;
                r.wide = 1'b1;
                r.first_idx = it.dest;
                r.word_lo = lo;
                r.word_hi = hi;
            end
        end else begin
            r.code = ERR_UNSUPPORTED;
        end
        return r;
    endfunction

    task automatic enqueue(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] dest,
                           logic [KIND_W-1:0] kind, logic [IDX_W-1:0] src,
                           logic [WORD_W-1:0] imm);
        t_move_item it;
        it.cmd = cmd;
        it.dest = dest;
        it.kind = kind;
        it.src = src;
        it.imm = imm;
        move_queue.push_back(it);
        issued_total++;
    endtask

    // Half the picks from a small window so moves read back earlier writes; some out of range
    function automatic logic [IDX_W-1:0] pick_reg(bit even);
        logic [IDX_W-1:0] v;
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 5)
            v = IDX_W'($urandom_range(0, 15));
        else if (r < 9)
            v = IDX_W'($urandom_range(0, SMRU_REG_COUNT - 1));
        else
            v = IDX_W'($urandom());
        if (even && $urandom_range(0, 9) != 0)
            v[0] = 1'b0;
        return v;
    endfunction

    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return $urandom();
        endcase
    endfunction

    task automatic enqueue_random();
        int unsigned r;
        logic [KIND_W-1:0] kind;
        r = $urandom_range(0, 99);
        kind = ($urandom_range(0, 9) < 3) ? KIND_REG : KIND_W'($urandom_range(0, 7));
        if (r < 45)
            enqueue(CMD_MOV32, pick_reg(1'b0), kind, pick_reg(1'b0), pick_word());
        else if (r < 85)
            enqueue(CMD_MOV64, pick_reg(1'b1), KIND_W'($urandom()), pick_reg(1'b1),
                    $urandom());
        else
            enqueue(CMD_W'($urandom()), IDX_W'($urandom()), KIND_W'($urandom()),
                    IDX_W'($urandom()), $urandom());
    endtask

    // One config register write; the shadow is updated when the write is driven
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        case (idx)
            CFG_VCC:  vcc_shadow = data;
            CFG_EXEC: exec_shadow = data;
            CFG_M0:   m0_shadow = data[WORD_W-1:0];
            default:  ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic load_settings(logic [63:0] vcc, logic [63:0] ex, logic [WORD_W-1:0] m0);
        write_reg(CFG_VCC, vcc);
        write_reg(CFG_EXEC, ex);
        write_reg(CFG_M0, {32'b0, m0});
    endtask

    // Wait until every issued item went in and every report came back
    task automatic drain();
        while (accepted_total != issued_total || report_queue.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic check_field(string name, logic [WORD_W-1:0] want, logic [WORD_W-1:0] seen);
        if (want !== seen) begin
            $error("%s: expected %0h, got %0h", name, want, seen);
            mismatches++;
        end
    endtask

    // Input driver: new item only once the previous one was taken
    always @(negedge i_clk) begin
        t_move_item nxt;
        if (!i_rst_n) begin
            io_in.valid <= 1'b0;
        end else if (!io_in.valid || in_taken) begin
            if (move_queue.size() != 0 && (calm || $urandom_range(0, 99) >= STALL_PERCENT)) begin
                nxt = move_queue.pop_front();
                io_in.valid        <= 1'b1;
                io_in.cmd          <= nxt.cmd;
                io_in.dest_index   <= nxt.dest;
                io_in.source_kind  <= nxt.kind;
                io_in.source_index <= nxt.src;
                io_in.immediate    <= nxt.imm;
            end else begin
                io_in.valid <= 1'b0;
            end
        end
    end

    // Result side back-pressure
    always @(negedge i_clk) begin
        io_out.ready <= i_rst_n && (calm || $urandom_range(0, 99) >= STALL_PERCENT);
    end

    // Monitor: predict on each accepted item, compare each accepted report
    always @(posedge i_clk) begin
        t_move_item   got;
        t_move_report want;
        in_taken <= io_in.valid && io_in.ready;
        if (io_in.valid && io_in.ready) begin
            got.cmd  = io_in.cmd;
            got.dest = io_in.dest_index;
            got.kind = io_in.source_kind;
            got.src  = io_in.source_index;
            got.imm  = io_in.immediate;
            report_queue.push_back(predict_move(got));
            accepted_total++;
        end
        calm <= accepted_total >= CALM_FROM && accepted_total < CALM_TO;
        if (io_out.valid && io_out.ready) begin
            if (report_queue.size() == 0) begin
                $error("result with no item outstanding");
                mismatches++;
            end else begin
                want = report_queue.pop_front();
                check_field("error_code", want.code, io_out.error_code);
                check_field("error_role", want.role, io_out.error_role);
                check_field("error_index", want.bad_index, io_out.error_index);
                check_field("wide_write", want.wide, io_out.wide_write);
                check_field("first_written", want.first_idx, io_out.first_written);
                check_field("value_low", want.word_lo, io_out.value_low);
                check_field("value_high", want.word_hi, io_out.value_high);
            end
        end
    end

    // Watchdog on cycles with no traffic on either channel
    always @(posedge i_clk) begin
        if ((io_in.valid && io_in.ready) || (io_out.valid && io_out.ready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    // Sequence: reset, directed moves, then random phases under several settings
    initial begin
        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_index        = '0;
        i_cfg_data         = '0;
        io_in.valid        = 1'b0;
        io_in.cmd          = '0;
        io_in.dest_index   = '0;
        io_in.source_kind  = '0;
        io_in.source_index = '0;
        io_in.immediate    = '0;
        io_out.ready       = 1'b0;
        issued_total       = 0;
        accepted_total     = 0;
        stuck_cycles       = 0;
        mismatches         = 0;
        in_taken           = 1'b0;
        calm               = 1'b0;
        vcc_shadow         = '0;
        exec_shadow        = '0;
        m0_shadow          = '0;
        for (int i = 0; i < SMRU_REG_COUNT; i++)
            sreg_shadow[i] = '0;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Distinct halves so a swapped half shows up
        load_settings(64'h89AB_CDEF_0123_4567, 64'hF0E1_D2C3_B4A5_9687, 32'h5A5A_A5A5);

        // Directed: edges of the file, every source kind, error ordering
        enqueue(CMD_MOV32, 8'd0,   KIND_REG,     8'd127, 32'h0);
        enqueue(CMD_MOV32, 8'd127, KIND_IMM,     8'd0,   32'hFFFF_FFFF);
        enqueue(CMD_MOV32, 8'd1,   KIND_IMM,     8'd0,   32'hA5A5_5A5A);
        enqueue(CMD_MOV32, 8'd2,   KIND_VCC_LO,  8'd0,   32'h0);
        enqueue(CMD_MOV32, 8'd3,   KIND_VCC_HI,  8'd0,   32'h0);
        enqueue(CMD_MOV32, 8'd4,   KIND_M0,      8'd0,   32'h0);
        enqueue(CMD_MOV32, 8'd5,   KIND_EXEC_LO, 8'd0,   32'h0);
        enqueue(CMD_MOV32, 8'd6,   KIND_EXEC_HI, 8'd0,   32'h0);
        enqueue(CMD_MOV32, 8'd7,   KIND_NULL,    8'd255, 32'hFFFF_FFFF);
        enqueue(CMD_MOV32, 8'd8,   KIND_REG,     8'd127, 32'h0);
        // bad destination wins over bad source
        enqueue(CMD_MOV32, 8'd128, KIND_REG,     8'd255, 32'h0);
        enqueue(CMD_MOV32, 8'd255, KIND_IMM,     8'd0,   32'h1234_5678);
        enqueue(CMD_MOV32, 8'd9,   KIND_REG,     8'd128, 32'h0);
        enqueue(CMD_MOV32, 8'd9,   KIND_REG,     8'd255, 32'h0);
        // pair moves at both ends; kind and immediate ignored
        enqueue(CMD_MOV64, 8'd0,   KIND_IMM,     8'd126, 32'hFFFF_FFFF);
        enqueue(CMD_MOV64, 8'd126, KIND_NULL,    8'd2,   32'h0);
        enqueue(CMD_MOV64, 8'd4,   KIND_REG,     8'd4,   32'h0);
        enqueue(CMD_MOV64, 8'd1,   KIND_REG,     8'd3,   32'h0);
        enqueue(CMD_MOV64, 8'd128, KIND_REG,     8'd0,   32'h0);
        enqueue(CMD_MOV64, 8'd254, KIND_REG,     8'd0,   32'h0);
        enqueue(CMD_MOV64, 8'd6,   KIND_REG,     8'd127, 32'h0);
        enqueue(CMD_MOV64, 8'd6,   KIND_REG,     8'd128, 32'h0);
        enqueue(CMD_OTHER, 8'd2,   KIND_REG,     8'd2,   32'h0);
        enqueue(CMD_UNDEFINED, 8'd255, KIND_IMM, 8'd255, 32'hFFFF_FFFF);
        enqueue(CMD_MOV32, 8'd10,  KIND_REG,     8'd0,   32'h0);
        drain();

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0:       load_settings('0, '0, '0);
                1:       load_settings('1, '1, '1);
                default: load_settings({$urandom(), $urandom()}, {$urandom(), $urandom()},
                                       $urandom());
            endcase
            repeat (ITEMS_PER_PHASE) enqueue_random();
            drain();
        end

        repeat (20) @(negedge i_clk);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
